FILE: hdl/tdf_pkg.sv
`timescale 1ns / 1ps

package tdf_pkg;

  localparam int VALUE_BITS     = 31;
  localparam int NUM_PRIMES     = 25;
  localparam int PRIME_BITS     = 7;
  localparam int IDX_BITS       = 5;
  localparam int EXP_BITS       = 5;
  localparam int KIND_BITS      = 2;
  localparam int MAX_RESULTS    = 10;
  localparam int CNT_BITS       = $clog2(MAX_RESULTS);
  localparam int DIV_CNT_BITS   = $clog2(VALUE_BITS + 1);
  localparam int IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((VALUE_BITS + EXP_BITS + 7) / 8) * 8;

  localparam logic [KIND_BITS-1:0] KIND_PRIME    = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_LEFTOVER = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_INVALID  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT,
    ST_ADVANCE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [PRIME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [PRIME_BITS-1:0] remainder;
  } div_rsp_t;

  function automatic logic [PRIME_BITS-1:0] prime_at(input logic [IDX_BITS-1:0] idx);
    logic [PRIME_BITS-1:0] p;
    unique case (idx)
      5'd0:    p = 7'd2;
      5'd1:    p = 7'd3;
      5'd2:    p = 7'd5;
      5'd3:    p = 7'd7;
      5'd4:    p = 7'd11;
      5'd5:    p = 7'd13;
      5'd6:    p = 7'd17;
      5'd7:    p = 7'd19;
      5'd8:    p = 7'd23;
      5'd9:    p = 7'd29;
      5'd10:   p = 7'd31;
      5'd11:   p = 7'd37;
      5'd12:   p = 7'd41;
      5'd13:   p = 7'd43;
      5'd14:   p = 7'd47;
      5'd15:   p = 7'd53;
      5'd16:   p = 7'd59;
      5'd17:   p = 7'd61;
      5'd18:   p = 7'd67;
      5'd19:   p = 7'd71;
      5'd20:   p = 7'd73;
      5'd21:   p = 7'd79;
      5'd22:   p = 7'd83;
      5'd23:   p = 7'd89;
      5'd24:   p = 7'd97;
      default: p = 7'd2;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/tdf_serial_div.sv
`timescale 1ns / 1ps

module tdf_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  tdf_pkg::div_req_t req,
  output tdf_pkg::div_rsp_t rsp
);

  logic                                  busy;
  logic                                  done;
  logic [tdf_pkg::DIV_CNT_BITS-1:0]      cnt;
  logic [tdf_pkg::VALUE_BITS-1:0]        work;
  logic [tdf_pkg::PRIME_BITS-1:0]        rem;
  logic [tdf_pkg::PRIME_BITS-1:0]        divisor;
  logic [tdf_pkg::PRIME_BITS:0]          trial;
  logic [tdf_pkg::PRIME_BITS:0]          diff;
  logic                                  ge;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial = {rem, work[tdf_pkg::VALUE_BITS-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= tdf_pkg::DIV_CNT_BITS'(tdf_pkg::VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tdf_pkg::DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      work <= {work[tdf_pkg::VALUE_BITS-2:0], ge};
      rem  <= ge ? diff[tdf_pkg::PRIME_BITS-1:0] : trial[tdf_pkg::PRIME_BITS-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = work;
  assign rsp.remainder = rem;

endmodule

FILE: hdl/trial_division_factorizer_unit.sv
`timescale 1ns / 1ps

// Factors one unsigned value over the primes 2 to 97 by trial division. Each
// input word gives, in ascending order, one output word per dividing prime
// (prime and exponent, tuser 0), then possibly a leftover cofactor above 1
// (exponent 1, tuser 1); values 0 and 1 give one word with tuser 2. tlast
// marks the final word of each input. All remainder tests run on one shared
// bit-serial divider; a value needs at most one division per prime tried plus
// one per prime factor counted with multiplicity. A new input word is taken
// once the previous one has handed its final result to the output register.
module trial_division_factorizer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tdf_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tdf_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,   // factor, exponent
  output logic [tdf_pkg::KIND_BITS-1:0]       m_axis_tuser,   // kind
  output logic                                m_axis_tlast    // last
);

  tdf_pkg::state_t                     state, state_next;
  logic [tdf_pkg::VALUE_BITS-1:0]      residual, residual_next;
  logic [tdf_pkg::IDX_BITS-1:0]        prime_index, prime_index_next;
  logic [tdf_pkg::EXP_BITS-1:0]        exponent_count, exponent_count_next;
  logic [tdf_pkg::CNT_BITS-1:0]        result_count, result_count_next;
  logic [tdf_pkg::VALUE_BITS-1:0]      pend_factor, pend_factor_next;
  logic [tdf_pkg::EXP_BITS-1:0]        pend_exponent, pend_exponent_next;
  logic [tdf_pkg::KIND_BITS-1:0]       pend_kind, pend_kind_next;
  logic                                pend_last, pend_last_next;

  logic                                out_valid;
  logic [tdf_pkg::VALUE_BITS-1:0]      out_factor;
  logic [tdf_pkg::EXP_BITS-1:0]        out_exponent;
  logic [tdf_pkg::KIND_BITS-1:0]       out_kind;
  logic                                out_last;
  logic                                slot_free;
  logic                                load_out;

  logic [tdf_pkg::VALUE_BITS-1:0]      in_value;
  logic [tdf_pkg::PRIME_BITS-1:0]      prime;
  logic [tdf_pkg::EXP_BITS-1:0]        exp_inc;
  tdf_pkg::div_req_t                   div_req;
  tdf_pkg::div_rsp_t                   div_rsp;

  tdf_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_value  = s_axis_tdata[tdf_pkg::VALUE_BITS-1:0];
  assign prime     = tdf_pkg::prime_at(prime_index);
  assign exp_inc   = (exponent_count == '1) ? exponent_count : exponent_count + 1'b1;
  assign slot_free = !out_valid || m_axis_tready;

  assign div_req.start    = (state == tdf_pkg::ST_START);
  assign div_req.dividend = residual;
  assign div_req.divisor  = prime;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residual       <= '0;
      prime_index    <= '0;
      exponent_count <= '0;
      result_count   <= '0;
    end else begin
      residual       <= residual_next;
      prime_index    <= prime_index_next;
      exponent_count <= exponent_count_next;
      result_count   <= result_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_factor   <= pend_factor_next;
    pend_exponent <= pend_exponent_next;
    pend_kind     <= pend_kind_next;
    pend_last     <= pend_last_next;
  end

  always_comb begin
    state_next          = state;
    residual_next       = residual;
    prime_index_next    = prime_index;
    exponent_count_next = exponent_count;
    result_count_next   = result_count;
    pend_factor_next    = pend_factor;
    pend_exponent_next  = pend_exponent;
    pend_kind_next      = pend_kind;
    pend_last_next      = pend_last;
    s_axis_tready       = 1'b0;
    load_out            = 1'b0;
    unique case (state)
      tdf_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          residual_next       = in_value;
          prime_index_next    = '0;
          exponent_count_next = '0;
          result_count_next   = '0;
          if (in_value < tdf_pkg::VALUE_BITS'(2)) begin
            pend_factor_next   = '0;
            pend_exponent_next = '0;
            pend_kind_next     = tdf_pkg::KIND_INVALID;
            pend_last_next     = 1'b1;
            state_next         = tdf_pkg::ST_EMIT;
          end else begin
            state_next = tdf_pkg::ST_START;
          end
        end
      end
      tdf_pkg::ST_START: begin
        state_next = tdf_pkg::ST_WAIT;
      end
      tdf_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            residual_next       = div_rsp.quotient;
            exponent_count_next = exp_inc;
            if (div_rsp.quotient == tdf_pkg::VALUE_BITS'(1)) begin
              pend_factor_next   = tdf_pkg::VALUE_BITS'(prime);
              pend_exponent_next = exp_inc;
              pend_kind_next     = tdf_pkg::KIND_PRIME;
              pend_last_next     = 1'b1;
              state_next         = tdf_pkg::ST_EMIT;
            end else begin
              state_next = tdf_pkg::ST_START;
            end
          end else if (exponent_count != '0) begin
            pend_factor_next   = tdf_pkg::VALUE_BITS'(prime);
            pend_exponent_next = exponent_count;
            pend_kind_next     = tdf_pkg::KIND_PRIME;
            pend_last_next     = 1'b0;
            state_next         = tdf_pkg::ST_EMIT;
          end else begin
            state_next = tdf_pkg::ST_ADVANCE;
          end
        end
      end
      tdf_pkg::ST_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (pend_last) begin
            state_next = tdf_pkg::ST_IDLE;
          end else begin
            result_count_next = result_count + 1'b1;
            state_next        = tdf_pkg::ST_ADVANCE;
          end
        end
      end
      tdf_pkg::ST_ADVANCE: begin
        // residual is above one here
        exponent_count_next = '0;
        if (result_count == tdf_pkg::CNT_BITS'(tdf_pkg::MAX_RESULTS - 1) ||
            prime_index == tdf_pkg::IDX_BITS'(tdf_pkg::NUM_PRIMES - 1)) begin
          pend_factor_next   = residual;
          pend_exponent_next = tdf_pkg::EXP_BITS'(1);
          pend_kind_next     = tdf_pkg::KIND_LEFTOVER;
          pend_last_next     = 1'b1;
          state_next         = tdf_pkg::ST_EMIT;
        end else begin
          prime_index_next = prime_index + 1'b1;
          state_next       = tdf_pkg::ST_START;
        end
      end
      default: begin
        state_next = tdf_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_factor   <= pend_factor;
      out_exponent <= pend_exponent;
      out_kind     <= pend_kind;
      out_last     <= pend_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(tdf_pkg::OUT_TDATA_BITS - tdf_pkg::VALUE_BITS
                            - tdf_pkg::EXP_BITS){1'b0}}, out_exponent, out_factor};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

FILE: hdl/tdf_checker.sv
`timescale 1ns / 1ps

module tdf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [tdf_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input logic [tdf_pkg::KIND_BITS-1:0]       m_axis_tuser,
  input logic                                m_axis_tlast
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // one value in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again straight after a value");

  a_invalid_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tdf_pkg::KIND_INVALID |->
      m_axis_tlast && m_axis_tdata == '0)
    else $error("invalid input word malformed");

  a_leftover_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tdf_pkg::KIND_LEFTOVER |->
      m_axis_tlast &&
      m_axis_tdata[tdf_pkg::VALUE_BITS +: tdf_pkg::EXP_BITS] == tdf_pkg::EXP_BITS'(1))
    else $error("leftover word malformed");

endmodule

bind trial_division_factorizer_unit tdf_checker u_tdf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
